### rtl/frame_ring_fifo_defines.svh
// Assertion macros for the frame ring FIFO.
// Included by the module that carries concurrent assertions, frame_ring_fifo; needs nothing else.
`ifndef FRAME_RING_FIFO_DEFINES_SVH
`define FRAME_RING_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
`define FRF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frame_ring_fifo: assertion failed");
`define FRF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("frame_ring_fifo: forbidden condition seen");
`else
`define FRF_ASSERT(lbl, clk, rst_n, prop)
`define FRF_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### rtl/frf_pkg.sv
// Shared constants, codes and types of the frame ring FIFO.
// Used by the byte bank, the top level, the checker and the testbench.
package frf_pkg;

    localparam int RING_BYTES = 1024;
    localparam int RING_AW    = $clog2(RING_BYTES);
    localparam int BANK_AW    = RING_AW - 1;
    localparam int BANK_DEPTH = RING_BYTES / 2;
    localparam int HDR_BYTES  = 2;
    localparam int LEN_CW     = 18;

    localparam logic [1:0] CMD_PUSH_START = 2'd0;
    localparam logic [1:0] CMD_PUSH_BYTE  = 2'd1;
    localparam logic [1:0] CMD_POP_START  = 2'd2;
    localparam logic [1:0] CMD_POP_BYTE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_ROOM = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_CORRUPT = 3'd3;
    localparam logic [2:0] ST_SEQ_ERR = 3'd4;

    typedef logic [RING_AW-1:0] t_ptr;
    typedef logic [BANK_AW-1:0] t_bidx;
    typedef logic [LEN_CW-1:0]  t_cnt;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] frame_len;
        logic [7:0]  in_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_len;
        logic [7:0]  out_byte;
        logic        last;
        logic        is_empty;
    } t_result;

    typedef struct packed {
        logic       we;
        t_bidx      addr;
        logic [7:0] data;
    } t_bank_wr;

    typedef struct packed {
        logic  re;
        t_bidx addr;
    } t_bank_rd;

endpackage

### rtl/frf_channels.sv
// Valid/ready channel interfaces for the items and results of the frame ring FIFO.
// Depends on nothing; the payload fields follow the package field widths.
interface frf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] frame_len;
    logic [7:0]  in_byte;

    modport source (output valid, output cmd, output frame_len, output in_byte, input ready);
    modport sink (input valid, input cmd, input frame_len, input in_byte, output ready);
endinterface

interface frf_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] out_len;
    logic [7:0]  out_byte;
    logic        last;
    logic        is_empty;

    modport source (output valid, output status, output out_len, output out_byte,
                    output last, output is_empty, input ready);
    modport sink (input valid, input status, input out_len, input out_byte,
                  input last, input is_empty, output ready);
endinterface

### rtl/frf_bank.sv
// One byte bank of the ring: half the ring bytes, one write and one registered read.
// Depends on frf_pkg. A read of the address written in the same cycle returns the new byte.
module frf_bank
    import frf_pkg::*;
(
    input  logic       i_clk,
    input  t_bank_wr   i_wr,
    input  t_bank_rd   i_rd,
    output logic [7:0] o_rdata
);

    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.re) begin
            if (i_wr.we && (i_wr.addr == i_rd.addr)) begin
                r_rdata <= i_wr.data;
            end else begin
                r_rdata <= mem[i_rd.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/frame_ring_fifo.sv
// Frame ring FIFO: frames of bytes behind a two-byte length header in a byte ring.
// One item is taken per clock unless stalled; its result is registered, and a result
// that is not taken holds one more item in the input register before the input stalls.
// The rate is set by the two byte banks (even and odd addresses), each with one write
// and one read port, so both bytes of a header are moved in the same cycle.
// Depends on frf_pkg, frf_channels, frf_bank and frame_ring_fifo_defines.svh.
`include "frame_ring_fifo_defines.svh"

module frame_ring_fifo
    import frf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    frf_item_if.sink          i_item,
    frf_result_if.source      o_result
);

    t_item   r_in;
    logic    r_in_vld;
    t_result r_out;
    logic    r_out_vld;
    logic    r_rd_sel;

    t_ptr        r_rd_ptr, n_rd_ptr;
    t_ptr        r_wr_ptr, n_wr_ptr;
    t_ptr        r_push_cur, n_push_cur;
    t_ptr        r_pop_cur, n_pop_cur;
    logic [15:0] r_push_left, n_push_left;
    logic [15:0] r_pop_left, n_pop_left;
    logic        r_pushing, n_pushing;
    logic        r_popping, n_popping;

    logic     w_fire;
    logic     w_accept;
    t_result  w_res;
    t_ptr     w_in_use;
    t_ptr     w_push_span;
    t_cnt     w_avail;
    t_cnt     w_need;
    logic     w_wr_do;
    logic     w_hdr;
    t_ptr     w_wa0, w_wa1;
    logic [7:0] w_wd0, w_wd1;
    t_ptr     w_ra0, w_ra1;
    t_ptr     w_nx_rd, w_nx_pop;
    logic [7:0] w_rdata0, w_rdata1;
    logic [7:0] w_byte0, w_byte1;
    logic [15:0] w_hdr_len;
    t_bank_wr w_bwr0, w_bwr1;
    t_bank_rd w_brd0, w_brd1;

    assign w_fire   = r_in_vld && (!r_out_vld || o_result.ready);
    assign w_accept = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_vld || w_fire;

    assign w_in_use    = r_wr_ptr - r_rd_ptr;
    assign w_push_span = r_push_cur - r_rd_ptr;
    assign w_avail     = t_cnt'(RING_BYTES - 1) - t_cnt'(w_in_use);
    assign w_need      = t_cnt'(HDR_BYTES) + t_cnt'(r_in.frame_len);

    assign w_byte0   = r_rd_sel ? w_rdata1 : w_rdata0;
    assign w_byte1   = r_rd_sel ? w_rdata0 : w_rdata1;
    assign w_hdr_len = {w_byte1, w_byte0};

    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_push_cur  = r_push_cur;
        n_pop_cur   = r_pop_cur;
        n_push_left = r_push_left;
        n_pop_left  = r_pop_left;
        n_pushing   = r_pushing;
        n_popping   = r_popping;
        w_res       = '0;
        w_res.status = ST_OK;
        w_wr_do     = 1'b0;
        w_hdr       = 1'b0;
        case (r_in.cmd)
            CMD_PUSH_START: begin
                if (r_pushing) begin
                    w_res.status = ST_SEQ_ERR;
                end else if (w_need > w_avail) begin
                    w_res.status = ST_NO_ROOM;
                end else begin
                    w_wr_do = 1'b1;
                    w_hdr   = 1'b1;
                    if (r_in.frame_len == 16'd0) begin
                        n_wr_ptr   = r_wr_ptr + t_ptr'(HDR_BYTES);
                        w_res.last = 1'b1;
                    end else begin
                        n_push_cur  = r_wr_ptr + t_ptr'(HDR_BYTES);
                        n_push_left = r_in.frame_len;
                        n_pushing   = 1'b1;
                    end
                end
            end
            CMD_PUSH_BYTE: begin
                if (!r_pushing) begin
                    w_res.status = ST_SEQ_ERR;
                end else begin
                    w_wr_do     = 1'b1;
                    n_push_cur  = r_push_cur + t_ptr'(1);
                    n_push_left = r_push_left - 16'd1;
                    if (r_push_left == 16'd1) begin
                        n_wr_ptr   = r_push_cur + t_ptr'(1);
                        n_pushing  = 1'b0;
                        w_res.last = 1'b1;
                    end
                end
            end
            CMD_POP_START: begin
                if (r_popping) begin
                    w_res.status = ST_SEQ_ERR;
                end else if (r_rd_ptr == r_wr_ptr) begin
                    w_res.status = ST_EMPTY;
                end else if ((w_hdr_len == 16'd0) ||
                             (t_cnt'(w_hdr_len) > t_cnt'(RING_BYTES - HDR_BYTES))) begin
                    n_rd_ptr     = r_wr_ptr;
                    w_res.status = ST_CORRUPT;
                end else begin
                    n_pop_cur     = r_rd_ptr + t_ptr'(HDR_BYTES);
                    n_pop_left    = w_hdr_len;
                    n_popping     = 1'b1;
                    w_res.out_len = w_hdr_len;
                end
            end
            default: begin
                if (!r_popping) begin
                    w_res.status = ST_SEQ_ERR;
                end else begin
                    w_res.out_byte = w_byte0;
                    n_pop_cur      = r_pop_cur + t_ptr'(1);
                    n_pop_left     = r_pop_left - 16'd1;
                    if (r_pop_left == 16'd1) begin
                        n_rd_ptr   = r_pop_cur + t_ptr'(1);
                        n_popping  = 1'b0;
                        w_res.last = 1'b1;
                    end
                end
            end
        endcase
        w_res.is_empty = (n_rd_ptr == n_wr_ptr);
    end

    // Write side: a header covers two neighboring bytes, one in each bank.
    assign w_wa0 = w_hdr ? r_wr_ptr : r_push_cur;
    assign w_wa1 = w_wa0 + t_ptr'(1);
    assign w_wd0 = w_hdr ? r_in.frame_len[7:0] : r_in.in_byte;
    assign w_wd1 = r_in.frame_len[15:8];

    always_comb begin
        if (!w_wa0[0]) begin
            w_bwr0 = '{we: w_wr_do && w_fire, addr: w_wa0[RING_AW-1:1], data: w_wd0};
            w_bwr1 = '{we: w_wr_do && w_hdr && w_fire, addr: w_wa1[RING_AW-1:1], data: w_wd1};
        end else begin
            w_bwr1 = '{we: w_wr_do && w_fire, addr: w_wa0[RING_AW-1:1], data: w_wd0};
            w_bwr0 = '{we: w_wr_do && w_hdr && w_fire, addr: w_wa1[RING_AW-1:1], data: w_wd1};
        end
    end

    // Read side: the banks are read for the incoming item from the pointers it will see.
    assign w_nx_rd  = w_fire ? n_rd_ptr : r_rd_ptr;
    assign w_nx_pop = w_fire ? n_pop_cur : r_pop_cur;
    assign w_ra0    = (i_item.cmd == CMD_POP_START) ? w_nx_rd : w_nx_pop;
    assign w_ra1    = w_ra0 + t_ptr'(1);

    always_comb begin
        if (!w_ra0[0]) begin
            w_brd0 = '{re: w_accept, addr: w_ra0[RING_AW-1:1]};
            w_brd1 = '{re: w_accept, addr: w_ra1[RING_AW-1:1]};
        end else begin
            w_brd1 = '{re: w_accept, addr: w_ra0[RING_AW-1:1]};
            w_brd0 = '{re: w_accept, addr: w_ra1[RING_AW-1:1]};
        end
    end

    frf_bank u_bank_even (
        .i_clk   (i_clk),
        .i_wr    (w_bwr0),
        .i_rd    (w_brd0),
        .o_rdata (w_rdata0)
    );

    frf_bank u_bank_odd (
        .i_clk   (i_clk),
        .i_wr    (w_bwr1),
        .i_rd    (w_brd1),
        .o_rdata (w_rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_push_cur  <= '0;
            r_pop_cur   <= '0;
            r_push_left <= '0;
            r_pop_left  <= '0;
            r_pushing   <= 1'b0;
            r_popping   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld   <= 1'b1;
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_push_cur  <= n_push_cur;
                r_pop_cur   <= n_pop_cur;
                r_push_left <= n_push_left;
                r_pop_left  <= n_pop_left;
                r_pushing   <= n_pushing;
                r_popping   <= n_popping;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.cmd       <= i_item.cmd;
            r_in.frame_len <= i_item.frame_len;
            r_in.in_byte   <= i_item.in_byte;
            r_rd_sel       <= w_ra0[0];
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid    = r_out_vld;
    assign o_result.status   = r_out.status;
    assign o_result.out_len  = r_out.out_len;
    assign o_result.out_byte = r_out.out_byte;
    assign o_result.last     = r_out.last;
    assign o_result.is_empty = r_out.is_empty;

    `FRF_ASSERT(a_push_left_live, i_clk, i_rst_n, r_pushing |-> (r_push_left != 16'd0))
    `FRF_ASSERT(a_pop_left_live, i_clk, i_rst_n, r_popping |-> (r_pop_left != 16'd0))
    `FRF_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_in_vld && !w_fire) |=> (r_in_vld && $stable(r_rd_ptr) && $stable(r_wr_ptr)))
    `FRF_ASSERT_NEVER(a_open_push_fits, i_clk, i_rst_n, r_pushing && ((t_cnt'(w_push_span) + t_cnt'(r_push_left)) > t_cnt'(RING_BYTES - 1)))

endmodule

### verif/frf_ring_checker.sv
// Checker for the frame ring FIFO: watches the item and result channels, predicts each result
// from a byte-level model of the ring, and compares it field by field with what the block returns.
// Depends on frf_pkg and the channel interfaces in frf_channels.
module frf_ring_checker
    import frf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    frf_item_if   i_item,
    frf_result_if i_result,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  ring_mem [RING_BYTES];
    t_ptr        rd_ptr;
    t_ptr        wr_ptr;
    t_ptr        push_at;
    t_ptr        pop_at;
    logic [15:0] push_rem;
    logic [15:0] pop_rem;
    logic        push_open;
    logic        pop_open;
    t_result     expected_results [$];
    int          mismatches = 0;

    function automatic t_result ring_step(input t_item it);
        t_result     r;
        t_ptr        p;
        logic [15:0] hdr;
        int          avail;
        r = '0;
        case (it.cmd)
            CMD_PUSH_START: begin
                avail = RING_BYTES - 1 - int'(t_ptr'(wr_ptr - rd_ptr));
                if (push_open) begin
                    r.status = ST_SEQ_ERR;
                end else if (avail < HDR_BYTES + int'(it.frame_len)) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    p = wr_ptr;
                    ring_mem[p] = it.frame_len[7:0];
                    p = p + 1'b1;
                    ring_mem[p] = it.frame_len[15:8];
                    p = p + 1'b1;
                    if (it.frame_len == 16'd0) begin
                        wr_ptr = p;
                        r.last = 1'b1;
                    end else begin
                        push_at   = p;
                        push_rem  = it.frame_len;
                        push_open = 1'b1;
                    end
                end
            end
            CMD_PUSH_BYTE: begin
                if (!push_open) begin
                    r.status = ST_SEQ_ERR;
                end else begin
                    ring_mem[push_at] = it.in_byte;
                    push_at  = push_at + 1'b1;
                    push_rem = push_rem - 1'b1;
                    if (push_rem == 16'd0) begin
                        wr_ptr    = push_at;
                        push_open = 1'b0;
                        r.last    = 1'b1;
                    end
                end
            end
            CMD_POP_START: begin
                if (pop_open) begin
                    r.status = ST_SEQ_ERR;
                end else if (rd_ptr == wr_ptr) begin
                    r.status = ST_EMPTY;
                end else begin
                    p = rd_ptr;
                    hdr[7:0] = ring_mem[p];
                    p = p + 1'b1;
                    hdr[15:8] = ring_mem[p];
                    p = p + 1'b1;
                    if (hdr == 16'd0 || int'(hdr) > RING_BYTES - HDR_BYTES) begin
                        rd_ptr   = wr_ptr;
                        r.status = ST_CORRUPT;
                    end else begin
                        pop_at    = p;
                        pop_rem   = hdr;
                        pop_open  = 1'b1;
                        r.out_len = hdr;
                    end
                end
            end
            default: begin
                if (!pop_open) begin
                    r.status = ST_SEQ_ERR;
                end else begin
                    r.out_byte = ring_mem[pop_at];
                    pop_at  = pop_at + 1'b1;
                    pop_rem = pop_rem - 1'b1;
                    if (pop_rem == 16'd0) begin
                        rd_ptr   = pop_at;
                        pop_open = 1'b0;
                        r.last   = 1'b1;
                    end
                end
            end
        endcase
        r.is_empty = (rd_ptr == wr_ptr);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            rd_ptr    = '0;
            wr_ptr    = '0;
            push_at   = '0;
            pop_at    = '0;
            push_rem  = '0;
            pop_rem   = '0;
            push_open = 1'b0;
            pop_open  = 1'b0;
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = {i_result.status, i_result.out_len, i_result.out_byte,
                       i_result.last, i_result.is_empty};
                if (expected_results.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.out_len !== want.out_len) begin
                        $error("out_len: expected %0d, got %0d", want.out_len, got.out_len);
                        mismatches++;
                    end
                    if (got.out_byte !== want.out_byte) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               want.out_byte, got.out_byte);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
                        mismatches++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_results.push_back(
                    ring_step({i_item.cmd, i_item.frame_len, i_item.in_byte}));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

### verif/tb_frame_ring_fifo.sv
// Top of the frame ring FIFO testbench: clock, reset, item stimulus and result backpressure.
// Directed frames probe the full ring, wrap and error cases; random frame traffic follows.
// Depends on frf_pkg, frf_channels, frame_ring_fifo and frf_ring_checker.
module tb_frame_ring_fifo;
    timeunit 1ns;
    timeprecision 1ps;
    import frf_pkg::*;

    localparam int RANDOM_ITEMS = 220;
    localparam int QUIET_ITEMS  = 60;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int FULL_FRAME   = RING_BYTES - 1 - HDR_BYTES;
    localparam int EMPTY_FRAMES = 500;
    localparam int TAIL_FRAME   = RING_BYTES - 1 - HDR_BYTES * (EMPTY_FRAMES + 1);

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   no_idle = 1'b0;

    // Frame-level view of the ring, kept only to steer the stimulus.
    int   frames_waiting [$];
    int   bytes_used = 0;
    bit   push_open = 1'b0;
    bit   pop_open = 1'b0;
    int   push_len = 0;
    int   push_rem = 0;
    int   pop_len = 0;
    int   pop_rem = 0;

    frf_item_if   item_ch ();
    frf_result_if result_ch ();

    frame_ring_fifo uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    frf_ring_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] len,
                             input logic [7:0] data);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= cmd;
        item_ch.frame_len <= len;
        item_ch.in_byte   <= data;
        forever begin
            @(posedge i_clk);
            if (item_ch.ready === 1'b1) break;
        end
        case (cmd)
            CMD_PUSH_START: begin
                if (!push_open && int'(len) + HDR_BYTES <= RING_BYTES - 1 - bytes_used) begin
                    if (len == 16'd0) begin
                        frames_waiting.push_back(0);
                        bytes_used += HDR_BYTES;
                    end else begin
                        push_open = 1'b1;
                        push_len  = int'(len);
                        push_rem  = int'(len);
                    end
                end
            end
            CMD_PUSH_BYTE: begin
                if (push_open) begin
                    push_rem--;
                    if (push_rem == 0) begin
                        frames_waiting.push_back(push_len);
                        bytes_used += HDR_BYTES + push_len;
                        push_open = 1'b0;
                    end
                end
            end
            CMD_POP_START: begin
                if (!pop_open && frames_waiting.size() > 0) begin
                    pop_len = frames_waiting.pop_front();
                    if (pop_len == 0) begin
                        frames_waiting.delete();
                        bytes_used = 0;
                    end else begin
                        pop_open = 1'b1;
                        pop_rem  = pop_len;
                    end
                end
            end
            default: begin
                if (pop_open) begin
                    pop_rem--;
                    if (pop_rem == 0) begin
                        bytes_used -= HDR_BYTES + pop_len;
                        pop_open = 1'b0;
                    end
                end
            end
        endcase
    endtask

    initial begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(0, 15);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int          pick;
        logic [15:0] len;
        logic [7:0]  data;
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.cmd       = CMD_PUSH_START;
        item_ch.frame_len = '0;
        item_ch.in_byte   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_POP_START, 16'd0, 8'd0);
        send_item(CMD_POP_BYTE, 16'd0, 8'd0);
        send_item(CMD_PUSH_BYTE, 16'hFFFF, 8'hFF);
        send_item(CMD_PUSH_START, 16'hFFFF, 8'd0);
        send_item(CMD_PUSH_START, 16'(FULL_FRAME + 1), 8'd0);
        // Empty frames and one closing frame fill the ring up to its last free byte.
        for (int i = 0; i < EMPTY_FRAMES; i++) begin
            send_item(CMD_PUSH_START, 16'd0, 8'd0);
        end
        send_item(CMD_PUSH_START, 16'(TAIL_FRAME + 1), 8'd0);
        send_item(CMD_PUSH_START, 16'(TAIL_FRAME), 8'd0);
        for (int i = 0; i < TAIL_FRAME; i++) begin
            data = (i == 0) ? 8'h00 : (i == TAIL_FRAME - 1) ? 8'hFF : 8'($urandom);
            send_item(CMD_PUSH_BYTE, 16'($urandom), data);
        end
        send_item(CMD_PUSH_START, 16'd0, 8'd0);
        send_item(CMD_POP_START, 16'd0, 8'd0);
        send_item(CMD_POP_START, 16'd0, 8'd0);
        // The next frame's header straddles the end of the ring.
        send_item(CMD_PUSH_START, 16'd3, 8'd0);
        send_item(CMD_PUSH_START, 16'd3, 8'd0);
        send_item(CMD_POP_START, 16'd0, 8'd0);
        for (int i = 0; i < 3; i++) begin
            send_item(CMD_PUSH_BYTE, 16'($urandom), 8'($urandom));
        end
        send_item(CMD_POP_START, 16'd0, 8'd0);
        send_item(CMD_POP_START, 16'd0, 8'd0);
        for (int i = 0; i < 3; i++) begin
            send_item(CMD_POP_BYTE, 16'($urandom), 8'($urandom));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
            if (n == RANDOM_ITEMS / 3) begin
                @(negedge i_clk);
                item_ch.valid <= 1'b0;
                forever begin
                    @(posedge i_clk);
                    if (pending == 0) break;
                end
            end
            pick = $urandom_range(0, 99);
            data = 8'($urandom);
            if (pick < 8) begin
                send_item(2'($urandom_range(0, 3)), 16'($urandom), data);
            end else if (pick < 54 || (!pop_open && frames_waiting.size() == 0)) begin
                if (push_open) begin
                    send_item(CMD_PUSH_BYTE, 16'($urandom), data);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6) len = 16'd0;
                    else if (pick < 80) len = 16'($urandom_range(1, 16));
                    else if (pick < 95) len = 16'($urandom_range(17, 120));
                    else len = 16'($urandom);
                    send_item(CMD_PUSH_START, len, data);
                end
            end else if (pop_open) begin
                send_item(CMD_POP_BYTE, 16'($urandom), data);
            end else begin
                send_item(CMD_POP_START, 16'($urandom), data);
            end
        end

        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pending == 0) break;
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
